/* rtl/core/u8u16_pkg.sv */
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 transcoder core.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    localparam int unsigned RES_FIFO_DEPTH = 4;

    localparam logic [15:0] CAP_RESET   = 16'hFFFF;
    localparam logic [15:0] REPLACEMENT = 16'hFFFD;
    localparam logic [15:0] HI_SURR     = 16'hD800;
    localparam logic [15:0] LO_SURR     = 16'hDC00;
    localparam logic [20:0] SUPP_BASE   = 21'h010000;

    // One input request
    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_start;
    } t_in_req;

    // One result
    typedef struct packed {
        logic [15:0] code_unit;
        logic        replaced;
        logic        last_of_run;
        logic        string_done;
        logic [15:0] units_written;
    } t_out_res;

    // Results produced by one request, compacted: res_a first
    typedef struct packed {
        logic [1:0] count;
        t_out_res   res_a;
        t_out_res   res_b;
    } t_push;

endpackage

/* rtl/core/u8u16_decode.sv */
// ----------------------------------------------------------------------------
// u8u16_decode
// Sequence state and single-pass decode of one UTF-8 byte into up to two
// UTF-16 code units, with replacement and capacity handling.
// ----------------------------------------------------------------------------
module u8u16_decode
    import u8u16_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_acc,
    input  t_in_req     i_req,
    input  logic [15:0] i_cap,
    output t_push       o_push
);

    logic [20:0] r_pv;
    logic [1:0]  r_tr;
    logic [2:0]  r_sl;
    logic [15:0] r_uc;
    logic        r_fin;
    logic        r_skip;

    logic [20:0] n_pv;
    logic [1:0]  n_tr;
    logic [2:0]  n_sl;
    logic [15:0] n_uc;
    logic        n_fin;
    logic        n_skip;

    t_push       push;

    always_comb begin
        logic [7:0]  b;
        logic        is_trail;
        logic [20:0] pv;
        logic [1:0]  tr;
        logic [2:0]  sl;
        logic [15:0] uc;
        logic        fin;
        logic        skip;
        logic        f_put;
        logic [15:0] f_unit;
        logic        f_repl;
        logic        f_nul;
        logic [20:0] f_pv;
        logic [1:0]  f_tr;
        logic [2:0]  f_sl;
        logic        req0, req1;
        logic [15:0] u0, u1;
        logic        rp0, rp1, nul0, nul1;
        logic [20:0] pvn;
        logic [19:0] cpm;
        logic        ok;
        logic        em0, em1;
        logic        dn0, dn1;
        logic [15:0] uw0, uw1;
        t_out_res    r0, r1;

        b        = i_req.in_byte;
        is_trail = (b[7:6] == 2'b10);

        // Start of string clears all string state first
        pv   = i_req.string_start ? '0 : r_pv;
        tr   = i_req.string_start ? '0 : r_tr;
        sl   = i_req.string_start ? '0 : r_sl;
        uc   = i_req.string_start ? '0 : r_uc;
        fin  = i_req.string_start ? 1'b0 : r_fin;
        skip = i_req.string_start ? 1'b0 : r_skip;

        // Classify the byte as a fresh lead
        f_put  = 1'b0;
        f_unit = REPLACEMENT;
        f_repl = 1'b0;
        f_nul  = 1'b0;
        f_pv   = '0;
        f_tr   = '0;
        f_sl   = '0;
        if (b[7] == 1'b0) begin
            f_put  = 1'b1;
            f_unit = {8'h00, b};
            f_nul  = (b == 8'h00);
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
            f_pv = {16'h0, b[4:0]};
            f_tr = 2'd1;
            f_sl = 3'd2;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
            f_pv = {17'h0, b[3:0]};
            f_tr = 2'd2;
            f_sl = 3'd3;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
            f_pv = {18'h0, b[2:0]};
            f_tr = 2'd3;
            f_sl = 3'd4;
        end else begin
            f_put  = 1'b1;
            f_repl = 1'b1;
        end

        req0 = 1'b0; u0 = '0; rp0 = 1'b0; nul0 = 1'b0;
        req1 = 1'b0; u1 = '0; rp1 = 1'b0; nul1 = 1'b0;
        pvn  = {pv[14:0], b[5:0]};
        cpm  = pvn[19:0] - SUPP_BASE[19:0];
        ok   = 1'b0;
        case (sl)
            3'd2:    ok = (pvn >= 21'h80);
            3'd3:    ok = (pvn >= 21'h800) && !(pvn >= 21'hD800 && pvn <= 21'hDFFF);
            3'd4:    ok = (pvn >= 21'h10000) && (pvn <= 21'h10FFFF);
            default: ok = 1'b0;
        endcase

        // Plan the units for this byte
        if (!fin) begin
            if (uc >= i_cap) begin
                fin = 1'b1;
            end else if (tr != 2'd0) begin
                if (is_trail) begin
                    tr = tr - 2'd1;
                    pv = pvn;
                    if (tr == 2'd0) begin
                        if (ok) begin
                            if (pvn < SUPP_BASE) begin
                                req0 = 1'b1;
                                u0   = pvn[15:0];
                            end else if (({1'b0, uc} + 17'd2) > {1'b0, i_cap}) begin
                                fin = 1'b1;
                            end else begin
                                req0 = 1'b1;
                                u0   = HI_SURR | {6'h00, cpm[19:10]};
                                req1 = 1'b1;
                                u1   = LO_SURR | {6'h00, pvn[9:0]};
                            end
                        end else begin
                            req0 = 1'b1;
                            u0   = REPLACEMENT;
                            rp0  = 1'b1;
                            skip = 1'b1;
                        end
                        pv = '0;
                        sl = '0;
                    end
                end else begin
                    // Truncated sequence: replace, then take the byte afresh
                    req0 = 1'b1;
                    u0   = REPLACEMENT;
                    rp0  = 1'b1;
                    req1 = f_put;
                    u1   = f_unit;
                    rp1  = f_repl;
                    nul1 = f_nul;
                    pv   = f_pv;
                    tr   = f_tr;
                    sl   = f_sl;
                    skip = f_repl;
                end
            end else if (skip && is_trail) begin
                // drop trail bytes after an error
                skip = 1'b1;
            end else begin
                req0 = f_put;
                u0   = f_unit;
                rp0  = f_repl;
                nul0 = f_nul;
                pv   = f_pv;
                tr   = f_tr;
                sl   = f_sl;
                skip = f_repl;
            end
        end

        // Write the planned units against the capacity
        em0 = 1'b0; dn0 = 1'b0; uw0 = uc;
        if (req0 && !fin) begin
            if (uc >= i_cap) begin
                fin = 1'b1;
            end else begin
                uc  = uc + 16'd1;
                em0 = 1'b1;
                dn0 = nul0 || (uc >= i_cap);
                uw0 = uc;
                fin = fin | dn0;
            end
        end
        em1 = 1'b0; dn1 = 1'b0; uw1 = uc;
        if (req1 && !fin) begin
            if (uc >= i_cap) begin
                fin = 1'b1;
            end else begin
                uc  = uc + 16'd1;
                em1 = 1'b1;
                dn1 = nul1 || (uc >= i_cap);
                uw1 = uc;
                fin = fin | dn1;
            end
        end

        r0 = '{code_unit: u0, replaced: rp0, last_of_run: !em1,
               string_done: dn0, units_written: uw0};
        r1 = '{code_unit: u1, replaced: rp1, last_of_run: 1'b1,
               string_done: dn1, units_written: uw1};

        push.count = i_acc ? ({1'b0, em0} + {1'b0, em1}) : 2'd0;
        push.res_a = em0 ? r0 : r1;
        push.res_b = r1;

        // Hold state when no request is taken
        if (i_acc) begin
            n_pv   = pv;
            n_tr   = tr;
            n_sl   = sl;
            n_uc   = uc;
            n_fin  = fin;
            n_skip = skip;
        end else begin
            n_pv   = r_pv;
            n_tr   = r_tr;
            n_sl   = r_sl;
            n_uc   = r_uc;
            n_fin  = r_fin;
            n_skip = r_skip;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv   <= '0;
            r_tr   <= '0;
            r_sl   <= '0;
            r_uc   <= '0;
            r_fin  <= 1'b0;
            r_skip <= 1'b0;
        end else begin
            r_pv   <= n_pv;
            r_tr   <= n_tr;
            r_sl   <= n_sl;
            r_uc   <= n_uc;
            r_fin  <= n_fin;
            r_skip <= n_skip;
        end
    end

    assign o_push = push;

endmodule

/* rtl/core/u8u16_res_fifo.sv */
// ----------------------------------------------------------------------------
// u8u16_res_fifo
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module u8u16_res_fifo
    import u8u16_pkg::*;
(
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  t_push                                i_push,
    input  logic                                 i_pop,
    output t_out_res                             o_head,
    output logic [$clog2(RES_FIFO_DEPTH+1)-1:0]  o_count
);

    localparam int unsigned PW = $clog2(RES_FIFO_DEPTH);
    localparam int unsigned CW = $clog2(RES_FIFO_DEPTH + 1);

    t_out_res        r_mem [RES_FIFO_DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic [PW-1:0]   wr_ptr_b;

    assign wr_ptr_b = r_wr_ptr + PW'(1);

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr + PW'(i_push.count);
        n_rd_ptr = r_rd_ptr + PW'(i_pop);
        n_count  = r_count + CW'(i_push.count) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store results
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res_a;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_b] <= i_push.res_b;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

/* rtl/core/utf8_to_utf16_transcoder_core.sv */
// A byte's results are decoded combinationally and registered into the
// result queue. One byte is taken per cycle while the input is not stalled;
// a byte yields zero, one or two units. Results drain one per cycle, unless
// the output stalls, through a four-entry queue; input stalls while fewer
// than two queue slots are free. Reset (synchronous, active low) clears
// string state and the queue and sets the unit capacity to 65535.
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_core
// UTF-8 byte stream to UTF-16 code units with replacement of ill-formed
// sequences and a per-string unit capacity.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_core
    import u8u16_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_req     i_in_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_res    o_out_res,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);

    localparam int unsigned CW = $clog2(RES_FIFO_DEPTH + 1);

    logic [15:0]   r_cap;
    logic          in_acc;
    logic          out_pop;
    t_push         push;
    logic [CW-1:0] q_count;

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    // Take a request only when two result slots are free
    assign o_in_stall = (q_count > CW'(RES_FIFO_DEPTH - 2));
    assign in_acc     = i_in_valid && !o_in_stall;

    u8u16_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (in_acc),
        .i_req   (i_in_req),
        .i_cap   (r_cap),
        .o_push  (push)
    );

    u8u16_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (out_pop),
        .o_head  (o_out_res),
        .o_count (q_count)
    );

    assign o_out_valid = (q_count != '0);
    assign out_pop     = o_out_valid && !i_out_stall;

    // Results only follow an accepted request
    a_no_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |-> (push.count == 2'd0))
        else $error("results pushed without a request");

    // Two results: only the second closes the run, and counts are consecutive
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.count == 2'd2) |->
            (!push.res_a.last_of_run && push.res_b.last_of_run &&
             (push.res_b.units_written == push.res_a.units_written + 16'd1)))
        else $error("pair results out of order");

    // Queue never overfills
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= CW'(RES_FIFO_DEPTH))
        else $error("result queue overflow");

    // A single result always closes its run
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.count == 2'd1) |-> push.res_a.last_of_run)
        else $error("single result not marked last");

endmodule
